// ===== sv/hec_pkg.sv =====
// hec_pkg: shared widths, register codes, config struct and position helpers
// for the Hamming encoder and parity checker. No dependencies.

package hec_pkg;

    localparam int DATA_W            = 32;  // data_word field width
    localparam int CODE_W            = 38;  // code_word / received_code width
    localparam int LEN_W             = 6;   // data_length register width
    localparam int N_W               = 7;   // holds codeword length up to 127
    localparam int PAR_N             = 6;   // parity positions 1,2,4,8,16,32
    localparam int ADDR_W            = 3;   // registers at byte 0 and 4
    localparam int APB_W             = 32;
    localparam int DEF_MAX_DATA_BITS = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_DATA_LENGTH = 1'b0,
        REG_ODD_PARITY  = 1'b1
    } t_reg_idx;

    // Static code setup seen by the datapath
    typedef struct packed {
        logic [CODE_W-1:0] pos_mask;   // bit pos-1 set when position pos <= n
        logic              odd_parity;
    } t_code_cfg;

    // Least r with 2^r >= m + r + 1
    function automatic logic [2:0] hec_parity_count(input logic [LEN_W-1:0] m);
        logic [2:0] r;
        logic       found;
        r     = 3'd7;
        found = 1'b0;
        for (int k = 1; k <= 7; k++) begin
            if (!found && ((8'd1 << k) >= (8'(m) + 8'(k) + 8'd1))) begin
                r     = 3'(k);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    // Position is a power of two (a parity position)
    function automatic logic hec_is_pow2(input int pos);
        return (pos & (pos - 1)) == 0;
    endfunction

    // Data bit index carried at a non-power-of-two position
    function automatic int hec_data_index(input int pos);
        int np;
        np = 0;
        for (int k = 0; k < PAR_N; k++) begin
            if ((1 << k) <= pos) np++;
        end
        return pos - 1 - np;
    endfunction

    // Positions covered by parity group k (position number has bit k set)
    function automatic logic [CODE_W-1:0] hec_group_mask(input int k);
        logic [CODE_W-1:0] g;
        g = '0;
        for (int pos = 1; pos <= CODE_W; pos++) begin
            g[pos-1] = ((pos >> k) & 1) != 0;
        end
        return g;
    endfunction

endpackage

// ===== sv/hec_in_if.sv =====
// hec_in_if: request channel (op, data word, received codeword).
// Depends on hec_pkg.

interface hec_in_if;
    import hec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [DATA_W-1:0]    data_word;
    logic [CODE_W-1:0]    received_code;

    modport source (output valid, op, data_word, received_code, input ready);
    modport sink   (input valid, op, data_word, received_code, output ready);
endinterface

// ===== sv/hec_out_if.sv =====
// hec_out_if: result channel (codeword, error flag).
// Depends on hec_pkg.

interface hec_out_if;
    import hec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CODE_W-1:0]    code_word;
    logic                 error_flag;

    modport source (output valid, code_word, error_flag, input ready);
    modport sink   (input valid, code_word, error_flag, output ready);
endinterface

// ===== sv/hec_core.sv =====
// hec_core: combinational Hamming encode and parity check over one request.
// Depends on hec_pkg.

module hec_core (
    input  logic                       i_op,
    input  logic [hec_pkg::DATA_W-1:0] i_data_word,
    input  logic [hec_pkg::CODE_W-1:0] i_received_code,
    input  hec_pkg::t_code_cfg         i_cfg,
    output logic [hec_pkg::CODE_W-1:0] o_code_word,
    output logic                       o_error_flag
);
    import hec_pkg::*;

    logic [CODE_W-1:0] w_data_pos;   // data bits placed, parity slots zero
    logic [CODE_W-1:0] w_rx;         // received word cut to length
    logic [CODE_W-1:0] w_code;
    logic [PAR_N-1:0]  w_fail;

    // Scatter data bits into non-power-of-two positions
    always_comb begin
        w_data_pos = '0;
        for (int pos = 1; pos <= CODE_W; pos++) begin
            if (!hec_is_pow2(pos)) begin
                w_data_pos[pos-1] = i_data_word[5'(hec_data_index(pos))];
            end
        end
        w_data_pos = w_data_pos & i_cfg.pos_mask;
    end

    assign w_rx = i_received_code & i_cfg.pos_mask;

    // Parity per group; a group exists only when its position is within length
    always_comb begin
        w_code = w_data_pos;
        w_fail = '0;
        for (int k = 0; k < PAR_N; k++) begin
            if (i_cfg.pos_mask[(1 << k) - 1]) begin
                w_code[(1 << k) - 1] = (^(w_data_pos & hec_group_mask(k)))
                                       ^ i_cfg.odd_parity;
                w_fail[k] = (^(w_rx & hec_group_mask(k))) ^ i_cfg.odd_parity;
            end
        end
    end

    assign o_code_word  = i_op ? '0 : w_code;
    assign o_error_flag = i_op ? (|w_fail) : 1'b0;

endmodule

// ===== sv/hamming_encode_and_check.sv =====
// hamming_encode_and_check: top level with APB config registers, request
// register, hec_core datapath and result register. Depends on hec_pkg,
// hec_in_if, hec_out_if, hec_core.
//
//  Channel   Dir  Handshake        Payload
//  i_req     in   valid/ready      op, data_word[31:0], received_code[37:0]
//  o_rsp     out  valid/ready      code_word[37:0], error_flag
//  apb       in   psel/penable     paddr[2:0], pwdata/prdata[31:0], pready=1
//
// One request per cycle while o_rsp is not stalled; a request is held in
// the request register, then in the result register after hec_core's XORs.
// Synchronous active-low reset empties both stages and sets data_length 32,
// odd_parity 0. A stalled result holds in the result register while the
// request register still takes one more request; i_req.ready drops only
// when both stages are full and o_rsp.ready is low.

module hamming_encode_and_check #(
    parameter int MAX_DATA_BITS = hec_pkg::DEF_MAX_DATA_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hec_in_if.sink                     i_req,
    hec_out_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hec_pkg::ADDR_W-1:0] paddr,
    input  logic [hec_pkg::APB_W-1:0]  pwdata,
    output logic [hec_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);
    import hec_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DATA_BITS);

    // Configuration registers
    logic [LEN_W-1:0] r_data_length;
    logic             r_odd_parity;
    t_reg_idx         w_reg_idx;
    logic             w_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_wr      = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= LEN_RESET;
            r_odd_parity  <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_DATA_LENGTH: r_data_length <= pwdata[LEN_W-1:0];
                REG_ODD_PARITY:  r_odd_parity  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_DATA_LENGTH: prdata = {{(APB_W-LEN_W){1'b0}}, r_data_length};
            REG_ODD_PARITY:  prdata = {{(APB_W-1){1'b0}}, r_odd_parity};
            default:         prdata = '0;
        endcase
    end

    // Effective length, codeword length and position mask
    logic [LEN_W-1:0] w_m;
    logic [N_W-1:0]   w_n;
    t_code_cfg        w_cfg;

    always_comb begin
        if (r_data_length == '0) begin
            w_m = LEN_W'(1);
        end else if (r_data_length > MAX_LEN) begin
            w_m = MAX_LEN;
        end else begin
            w_m = r_data_length;
        end
        w_n = N_W'(w_m) + N_W'(hec_parity_count(w_m));
        for (int pos = 1; pos <= CODE_W; pos++) begin
            w_cfg.pos_mask[pos-1] = N_W'(pos) <= w_n;
        end
        w_cfg.odd_parity = r_odd_parity;
    end

    // Request register
    logic              r_s1_valid;
    logic              r_s1_op;
    logic [DATA_W-1:0] r_s1_data;
    logic [CODE_W-1:0] r_s1_rx;
    logic              w_s1_ready;
    logic              w_s2_ready;

    assign w_s2_ready  = !o_rsp.valid || o_rsp.ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign i_req.ready = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_req.valid) begin
            r_s1_op   <= i_req.op;
            r_s1_data <= i_req.data_word;
            r_s1_rx   <= i_req.received_code;
        end
    end

    // Encode / check datapath
    logic [CODE_W-1:0] w_code_word;
    logic              w_error_flag;

    hec_core u_core (
        .i_op            (r_s1_op),
        .i_data_word     (r_s1_data),
        .i_received_code (r_s1_rx),
        .i_cfg           (w_cfg),
        .o_code_word     (w_code_word),
        .o_error_flag    (w_error_flag)
    );

    // Result register
    logic              r_s2_valid;
    logic [CODE_W-1:0] r_s2_code;
    logic              r_s2_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && r_s1_valid) begin
            r_s2_code <= w_code_word;
            r_s2_err  <= w_error_flag;
        end
    end

    assign o_rsp.valid      = r_s2_valid;
    assign o_rsp.code_word  = r_s2_code;
    assign o_rsp.error_flag = r_s2_err;

    // Assertions
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_s2_valid)
        else $error("pipeline not empty after reset");

    a_flag_or_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.error_flag && (o_rsp.code_word != '0)))
        else $error("result carries both a codeword and an error flag");

    a_word_in_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.code_word & ~w_cfg.pos_mask) == '0))
        else $error("codeword bits set above codeword length");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_ready) |=>
            (r_s1_valid && $stable(r_s1_op) && $stable(r_s1_data) && $stable(r_s1_rx)))
        else $error("stalled request register changed");

endmodule
